/* design/kalman_filter_cv_2state_unit_assert.svh */
// Assertion macros used by the tracker control unit.
`ifndef KALMAN_FILTER_CV_2STATE_UNIT_ASSERT_SVH
`define KALMAN_FILTER_CV_2STATE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define KF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker assertion failed");
`define KF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker assertion failed");
`else
`define KF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/kfcv_pkg.sv */
package kfcv_pkg;

    // Word format: signed Q16.32 in 48 bits.
    localparam int W      = 48;
    localparam int F      = 32;
    localparam int HW     = W / 2;
    localparam int RW     = 2 * W - F;
    localparam int ND     = W + F + 1;
    localparam int CNT_W  = $clog2(ND + 1);
    localparam int PC_W   = 6;
    localparam int PROG_LEN = 63;

    typedef logic signed [W-1:0] t_word;

    localparam t_word WMAX = {1'b0, {(W-1){1'b1}}};
    localparam t_word WMIN = {1'b1, {(W-1){1'b0}}};
    localparam t_word ONE  = t_word'(1) << F;

    // Register reset values.
    localparam logic [36:0] RST_TIME_STEP   = 37'd429496730;
    localparam logic [46:0] RST_ACCEL_NOISE = 47'd214748365;
    localparam logic [46:0] RST_MEAS_NOISE  = 47'd2147483648;
    localparam logic [47:0] RST_START_VEL   = 48'd2147483648;
    localparam logic [46:0] RST_START_VAR   = 47'd42949672960;

    typedef enum logic [2:0] {
        CFG_TIME_STEP, CFG_ACCEL_NOISE, CFG_MEAS_NOISE, CFG_FILTER_MODE,
        CFG_GAIN_POS, CFG_GAIN_VEL, CFG_START_VEL, CFG_START_VAR
    } t_cfg_idx;

    // Scratch register file addresses.
    typedef enum logic [5:0] {
        R_EP, R_EV, R_CP, R_CC, R_CV, R_Z, R_DT, R_XP, R_E, R_K0, R_K1, R_Q,
        R_R, R_ONE, R_DT2, R_DT3, R_DT4, R_T, R_U, R_Q00, R_Q01, R_Q11, R_M00,
        R_M01, R_P00, R_P01, R_P11, R_S, R_A, R_B, R_T00, R_T01, R_T10, R_T11,
        R_KR0, R_KR1
    } t_reg;

    localparam int NREG = 36;

    typedef enum logic [3:0] {
        OP_END, OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_QTR, OP_HALF,
        OP_NEG, OP_CLP, OP_CLV
    } t_op;

    typedef enum logic [1:0] {C_ALL, C_RST, C_M0, C_M1} t_cond;

    typedef enum logic [3:0] {
        SRC_ZERO, SRC_ONE, SRC_Z, SRC_DT, SRC_Q, SRC_R, SRC_GP, SRC_GV,
        SRC_SVEL, SRC_SVAR
    } t_src;

    typedef struct packed {
        t_cond cond;
        t_op   op;
        t_reg  dst;
        t_reg  a;
        t_reg  b;
        t_src  src;
    } t_uop;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_WAIT, S_OUT} t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic start;
        logic use_default;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic mode;
    } t_status;

    typedef struct packed {
        t_word val;
        logic  clip;
    } t_satres;

    function automatic t_uop mk(t_cond c, t_op o, t_reg d, t_reg a, t_reg b, t_src s);
        t_uop u;
        u.cond = c;
        u.op   = o;
        u.dst  = d;
        u.a    = a;
        u.b    = b;
        u.src  = s;
        return u;
    endfunction

    // Step program: restart, predict, gain, state and covariance update.
    function automatic t_uop ucode(logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(C_RST, OP_LD,   R_EP,  R_EP,  R_EP,  SRC_ZERO);
            6'd1:  u = mk(C_RST, OP_LD,   R_EV,  R_EP,  R_EP,  SRC_SVEL);
            6'd2:  u = mk(C_RST, OP_LD,   R_CP,  R_EP,  R_EP,  SRC_SVAR);
            6'd3:  u = mk(C_RST, OP_LD,   R_CV,  R_EP,  R_EP,  SRC_SVAR);
            6'd4:  u = mk(C_RST, OP_LD,   R_CC,  R_EP,  R_EP,  SRC_ZERO);
            6'd5:  u = mk(C_ALL, OP_LD,   R_Z,   R_EP,  R_EP,  SRC_Z);
            6'd6:  u = mk(C_ALL, OP_LD,   R_DT,  R_EP,  R_EP,  SRC_DT);
            6'd7:  u = mk(C_ALL, OP_MUL,  R_T,   R_DT,  R_EV,  SRC_ZERO);
            6'd8:  u = mk(C_ALL, OP_ADD,  R_XP,  R_EP,  R_T,   SRC_ZERO);
            6'd9:  u = mk(C_ALL, OP_SUB,  R_E,   R_Z,   R_XP,  SRC_ZERO);
            6'd10: u = mk(C_M1,  OP_LD,   R_K0,  R_EP,  R_EP,  SRC_GP);
            6'd11: u = mk(C_M1,  OP_LD,   R_K1,  R_EP,  R_EP,  SRC_GV);
            6'd12: u = mk(C_M0,  OP_LD,   R_Q,   R_EP,  R_EP,  SRC_Q);
            6'd13: u = mk(C_M0,  OP_LD,   R_R,   R_EP,  R_EP,  SRC_R);
            6'd14: u = mk(C_M0,  OP_LD,   R_ONE, R_EP,  R_EP,  SRC_ONE);
            6'd15: u = mk(C_M0,  OP_MUL,  R_DT2, R_DT,  R_DT,  SRC_ZERO);
            6'd16: u = mk(C_M0,  OP_MUL,  R_DT3, R_DT2, R_DT,  SRC_ZERO);
            6'd17: u = mk(C_M0,  OP_MUL,  R_DT4, R_DT2, R_DT2, SRC_ZERO);
            6'd18: u = mk(C_M0,  OP_MUL,  R_T,   R_Q,   R_DT4, SRC_ZERO);
            6'd19: u = mk(C_M0,  OP_QTR,  R_Q00, R_T,   R_T,   SRC_ZERO);
            6'd20: u = mk(C_M0,  OP_MUL,  R_T,   R_Q,   R_DT3, SRC_ZERO);
            6'd21: u = mk(C_M0,  OP_HALF, R_Q01, R_T,   R_T,   SRC_ZERO);
            6'd22: u = mk(C_M0,  OP_MUL,  R_Q11, R_Q,   R_DT,  SRC_ZERO);
            6'd23: u = mk(C_M0,  OP_MUL,  R_T,   R_DT,  R_CC,  SRC_ZERO);
            6'd24: u = mk(C_M0,  OP_ADD,  R_M00, R_CP,  R_T,   SRC_ZERO);
            6'd25: u = mk(C_M0,  OP_MUL,  R_T,   R_DT,  R_CV,  SRC_ZERO);
            6'd26: u = mk(C_M0,  OP_ADD,  R_M01, R_CC,  R_T,   SRC_ZERO);
            6'd27: u = mk(C_M0,  OP_MUL,  R_T,   R_DT,  R_M01, SRC_ZERO);
            6'd28: u = mk(C_M0,  OP_ADD,  R_T,   R_M00, R_T,   SRC_ZERO);
            6'd29: u = mk(C_M0,  OP_ADD,  R_P00, R_T,   R_Q00, SRC_ZERO);
            6'd30: u = mk(C_M0,  OP_ADD,  R_P01, R_M01, R_Q01, SRC_ZERO);
            6'd31: u = mk(C_M0,  OP_ADD,  R_P11, R_CV,  R_Q11, SRC_ZERO);
            6'd32: u = mk(C_M0,  OP_ADD,  R_S,   R_P00, R_R,   SRC_ZERO);
            6'd33: u = mk(C_M0,  OP_DIV,  R_K0,  R_P00, R_S,   SRC_ZERO);
            6'd34: u = mk(C_M0,  OP_DIV,  R_K1,  R_P01, R_S,   SRC_ZERO);
            6'd35: u = mk(C_M0,  OP_CLP,  R_K0,  R_K0,  R_ONE, SRC_ZERO);
            6'd36: u = mk(C_M0,  OP_CLV,  R_K1,  R_K1,  R_ONE, SRC_ZERO);
            6'd37: u = mk(C_M0,  OP_SUB,  R_A,   R_ONE, R_K0,  SRC_ZERO);
            6'd38: u = mk(C_M0,  OP_NEG,  R_B,   R_K1,  R_K1,  SRC_ZERO);
            6'd39: u = mk(C_M0,  OP_MUL,  R_T00, R_A,   R_P00, SRC_ZERO);
            6'd40: u = mk(C_M0,  OP_MUL,  R_T01, R_A,   R_P01, SRC_ZERO);
            6'd41: u = mk(C_M0,  OP_MUL,  R_T,   R_B,   R_P00, SRC_ZERO);
            6'd42: u = mk(C_M0,  OP_ADD,  R_T10, R_T,   R_P01, SRC_ZERO);
            6'd43: u = mk(C_M0,  OP_MUL,  R_T,   R_B,   R_P01, SRC_ZERO);
            6'd44: u = mk(C_M0,  OP_ADD,  R_T11, R_T,   R_P11, SRC_ZERO);
            6'd45: u = mk(C_M0,  OP_MUL,  R_KR0, R_K0,  R_R,   SRC_ZERO);
            6'd46: u = mk(C_M0,  OP_MUL,  R_KR1, R_K1,  R_R,   SRC_ZERO);
            6'd47: u = mk(C_M0,  OP_MUL,  R_T,   R_T00, R_A,   SRC_ZERO);
            6'd48: u = mk(C_M0,  OP_MUL,  R_U,   R_KR0, R_K0,  SRC_ZERO);
            6'd49: u = mk(C_M0,  OP_ADD,  R_CP,  R_T,   R_U,   SRC_ZERO);
            6'd50: u = mk(C_M0,  OP_MUL,  R_T,   R_T00, R_B,   SRC_ZERO);
            6'd51: u = mk(C_M0,  OP_ADD,  R_T,   R_T,   R_T01, SRC_ZERO);
            6'd52: u = mk(C_M0,  OP_MUL,  R_U,   R_KR0, R_K1,  SRC_ZERO);
            6'd53: u = mk(C_M0,  OP_ADD,  R_CC,  R_T,   R_U,   SRC_ZERO);
            6'd54: u = mk(C_M0,  OP_MUL,  R_T,   R_T10, R_B,   SRC_ZERO);
            6'd55: u = mk(C_M0,  OP_ADD,  R_T,   R_T,   R_T11, SRC_ZERO);
            6'd56: u = mk(C_M0,  OP_MUL,  R_U,   R_KR1, R_K1,  SRC_ZERO);
            6'd57: u = mk(C_M0,  OP_ADD,  R_CV,  R_T,   R_U,   SRC_ZERO);
            6'd58: u = mk(C_ALL, OP_MUL,  R_T,   R_K0,  R_E,   SRC_ZERO);
            6'd59: u = mk(C_ALL, OP_ADD,  R_EP,  R_XP,  R_T,   SRC_ZERO);
            6'd60: u = mk(C_ALL, OP_MUL,  R_T,   R_K1,  R_E,   SRC_ZERO);
            6'd61: u = mk(C_ALL, OP_ADD,  R_EV,  R_EV,  R_T,   SRC_ZERO);
            default: u = mk(C_ALL, OP_END, R_EP, R_EP, R_EP, SRC_ZERO);
        endcase
        return u;
    endfunction

    function automatic logic [W-1:0] mag(t_word a);
        return a[W-1] ? W'(-a) : W'(a);
    endfunction

    // Signed result from a magnitude, clipped to the word range.
    function automatic t_satres from_mag(logic [ND-1:0] m, logic neg);
        logic [ND-1:0] lim;
        logic [ND-1:0] lo;
        t_satres       r;
        lim = ND'(WMAX) + ND'(neg);
        lo  = m;
        r.clip = 1'b0;
        if (m > lim) begin
            lo     = lim;
            r.clip = 1'b1;
        end
        r.val = neg ? W'(-lo) : W'(lo);
        return r;
    endfunction

    function automatic t_satres sadd(t_word a, t_word b);
        logic [W:0] s;
        t_satres    r;
        s = {a[W-1], a} + {b[W-1], b};
        r.clip = s[W] != s[W-1];
        r.val  = r.clip ? (s[W] ? WMIN : WMAX) : s[W-1:0];
        return r;
    endfunction

    function automatic t_satres ssub(t_word a, t_word b);
        logic [W:0] s;
        t_satres    r;
        s = {a[W-1], a} - {b[W-1], b};
        r.clip = s[W] != s[W-1];
        r.val  = r.clip ? (s[W] ? WMIN : WMAX) : s[W-1:0];
        return r;
    endfunction

endpackage

/* design/kfcv_in_if.sv */
interface kfcv_in_if import kfcv_pkg::*;;
    logic         valid;
    logic         ready;
    logic [W-1:0] measurement;
    logic         restart;

    modport source (output valid, output measurement, output restart, input ready);
    modport sink (input valid, input measurement, input restart, output ready);
endinterface

/* design/kfcv_out_if.sv */
interface kfcv_out_if import kfcv_pkg::*;;
    logic         valid;
    logic         ready;
    logic [W-1:0] pos_estimate;
    logic [W-1:0] vel_estimate;
    logic [W-1:0] innovation;
    logic [32:0]  gain_pos_used;
    logic [33:0]  gain_vel_used;
    logic         saturated;

    modport source (output valid, output pos_estimate, output vel_estimate,
                    output innovation, output gain_pos_used, output gain_vel_used,
                    output saturated, input ready);
    modport sink (input valid, input pos_estimate, input vel_estimate,
                  input innovation, input gain_pos_used, input gain_vel_used,
                  input saturated, output ready);
endinterface

/* design/kfcv_ctrl.sv */
`include "kalman_filter_cv_2state_unit_assert.svh"
module kfcv_ctrl import kfcv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_restart,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic              r_restart, n_restart;
    logic              r_fresh, n_fresh;
    t_uop              uop;
    logic              cond_ok;

    // Fetch the current step of the program.
    assign uop = ucode(r_pc);

    always_comb begin
        case (uop.cond)
            C_ALL:   cond_ok = 1'b1;
            C_RST:   cond_ok = r_restart | r_fresh;
            C_M0:    cond_ok = !i_status.mode;
            C_M1:    cond_ok = i_status.mode;
            default: cond_ok = 1'b1;
        endcase
    end

    // Next state.
    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_restart = r_restart;
        n_fresh   = r_fresh;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state   = S_READ;
                    n_pc      = '0;
                    n_restart = i_restart;
                end
            end
            S_READ: begin
                if (uop.op == OP_END) begin
                    n_state = S_OUT;
                end else if (!cond_ok) begin
                    n_pc = r_pc + PC_W'(1);
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_WAIT;
            S_WAIT: begin
                if (i_status.done) begin
                    n_state = S_READ;
                    n_pc    = r_pc + PC_W'(1);
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                    n_fresh = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_ready        = r_state == S_IDLE;
        o_out_valid       = r_state == S_OUT;
        o_cmd.load        = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd          = (r_state == S_READ) && cond_ok && (uop.op != OP_END);
        o_cmd.start       = r_state == S_EXEC;
        o_cmd.use_default = r_fresh && !r_restart;
        o_cmd.uop         = uop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= '0;
            r_restart <= 1'b0;
            r_fresh   <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_restart <= n_restart;
            r_fresh   <= n_fresh;
        end
    end

    `KF_ASSERT_NXT(a_start_pulse, i_clk, i_rst_n, o_cmd.start, !o_cmd.start)
    `KF_ASSERT_IMP(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `KF_ASSERT_IMP(a_pc_range, i_clk, i_rst_n, 1'b1, r_pc < PC_W'(PROG_LEN))
    `KF_ASSERT_NXT(a_done_next, i_clk, i_rst_n, (r_state == S_WAIT) && i_status.done, r_state == S_READ)

endmodule

/* design/kfcv_dp.sv */
module kfcv_dp import kfcv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_status      o_status,
    input  logic [W-1:0] i_measurement,
    input  logic         i_cfg_we,
    input  t_cfg_idx     i_cfg_idx,
    input  logic [W-1:0] i_cfg_wdata,
    output logic [W-1:0] o_pos,
    output logic [W-1:0] o_vel,
    output logic [W-1:0] o_innov,
    output logic [32:0]  o_gain_pos,
    output logic [33:0]  o_gain_vel,
    output logic         o_sat
);

    // Configuration registers.
    logic [36:0] r_time_step;
    logic [46:0] r_accel_noise, r_meas_noise, r_start_var;
    logic        r_filter_mode;
    logic [32:0] r_gain_pos, r_gain_vel;
    logic [47:0] r_start_vel;

    t_word       mem [NREG];
    t_word       r_opa, r_opb, r_z;
    logic [W-1:0]   r_ma, r_mb, r_den;
    logic           r_neg, r_mul_act, r_div_act, r_done, r_clip;
    logic [2*W-1:0] r_acc;
    logic [RW-1:0]  r_rnd;
    logic [ND-1:0]  r_dvd, r_quo;
    logic [W-1:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0] r_pos, r_vel, r_innov;
    logic [32:0]  r_gpos;
    logic [33:0]  r_gvel;

    logic         wr_en, clip_set;
    t_word        wr_data, ld_val;
    t_satres      sr;
    logic [HW-1:0]   pa, pb;
    logic [2*HW-1:0] pp;
    logic [W:0]      remsh;
    logic            qbit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= RST_TIME_STEP;
            r_accel_noise <= RST_ACCEL_NOISE;
            r_meas_noise  <= RST_MEAS_NOISE;
            r_filter_mode <= 1'b0;
            r_gain_pos    <= '0;
            r_gain_vel    <= '0;
            r_start_vel   <= RST_START_VEL;
            r_start_var   <= RST_START_VAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIME_STEP:   r_time_step   <= i_cfg_wdata[36:0];
                CFG_ACCEL_NOISE: r_accel_noise <= i_cfg_wdata[46:0];
                CFG_MEAS_NOISE:  r_meas_noise  <= i_cfg_wdata[46:0];
                CFG_FILTER_MODE: r_filter_mode <= i_cfg_wdata[0];
                CFG_GAIN_POS:    r_gain_pos    <= i_cfg_wdata[32:0];
                CFG_GAIN_VEL:    r_gain_vel    <= i_cfg_wdata[32:0];
                CFG_START_VEL:   r_start_vel   <= i_cfg_wdata[47:0];
                CFG_START_VAR:   r_start_var   <= i_cfg_wdata[46:0];
                default:         r_filter_mode <= r_filter_mode;
            endcase
        end
    end

    assign o_status.mode = r_filter_mode;
    assign o_status.done = r_done;

    // Source selection for register loads.
    always_comb begin
        case (i_cmd.uop.src)
            SRC_ZERO: ld_val = '0;
            SRC_ONE:  ld_val = ONE;
            SRC_Z:    ld_val = r_z;
            SRC_DT:   ld_val = t_word'(r_time_step);
            SRC_Q:    ld_val = t_word'(r_accel_noise);
            SRC_R:    ld_val = t_word'(r_meas_noise);
            SRC_GP:   ld_val = t_word'(r_gain_pos);
            SRC_GV:   ld_val = t_word'(r_gain_vel);
            SRC_SVEL: ld_val = i_cmd.use_default ? t_word'(RST_START_VEL) : t_word'(r_start_vel);
            SRC_SVAR: ld_val = i_cmd.use_default ? t_word'(RST_START_VAR) : t_word'(r_start_var);
            default:  ld_val = '0;
        endcase
    end

    // One partial product of the 48-bit magnitude multiply per cycle.
    assign pa = r_cnt[1] ? r_ma[W-1:HW] : r_ma[HW-1:0];
    assign pb = r_cnt[0] ? r_mb[W-1:HW] : r_mb[HW-1:0];
    assign pp = pa * pb;

    // One restoring division step per cycle.
    assign remsh = {r_rem, r_dvd[ND-1]};
    assign qbit  = remsh >= {1'b0, r_den};

    // Result write-back for every operation.
    always_comb begin
        wr_en    = 1'b0;
        wr_data  = '0;
        clip_set = 1'b0;
        sr       = '0;
        if (i_cmd.start) begin
            case (i_cmd.uop.op)
                OP_LD: begin
                    wr_en   = 1'b1;
                    wr_data = ld_val;
                end
                OP_ADD: begin
                    sr       = sadd(r_opa, r_opb);
                    wr_en    = 1'b1;
                    wr_data  = sr.val;
                    clip_set = sr.clip;
                end
                OP_SUB: begin
                    sr       = ssub(r_opa, r_opb);
                    wr_en    = 1'b1;
                    wr_data  = sr.val;
                    clip_set = sr.clip;
                end
                OP_QTR: begin
                    wr_en   = 1'b1;
                    wr_data = (r_opa >>> 2) + t_word'(r_opa[1]);
                end
                OP_HALF: begin
                    wr_en   = 1'b1;
                    wr_data = (r_opa >>> 1) + t_word'(r_opa[0]);
                end
                OP_NEG: begin
                    wr_en   = 1'b1;
                    wr_data = -r_opa;
                end
                OP_CLP: begin
                    wr_en   = 1'b1;
                    wr_data = r_opa;
                    if (r_opa < 0) begin
                        wr_data  = '0;
                        clip_set = 1'b1;
                    end else if (r_opa > r_opb) begin
                        wr_data  = r_opb;
                        clip_set = 1'b1;
                    end
                end
                OP_CLV: begin
                    wr_en   = 1'b1;
                    wr_data = r_opa;
                    if (r_opa < -r_opb) begin
                        wr_data  = -r_opb;
                        clip_set = 1'b1;
                    end else if (r_opa > r_opb) begin
                        wr_data  = r_opb;
                        clip_set = 1'b1;
                    end
                end
                OP_DIV: begin
                    // A divisor that is not positive gives a zero gain.
                    if (r_opb <= 0) begin
                        wr_en   = 1'b1;
                        wr_data = '0;
                    end
                end
                default: wr_en = 1'b0;
            endcase
        end else if (r_mul_act && (r_cnt == CNT_W'(5))) begin
            sr       = from_mag(ND'(r_rnd), r_neg);
            wr_en    = 1'b1;
            wr_data  = sr.val;
            clip_set = sr.clip;
        end else if (r_div_act && (r_cnt == CNT_W'(ND))) begin
            sr       = from_mag(r_quo, r_neg);
            wr_en    = 1'b1;
            wr_data  = sr.val;
            clip_set = sr.clip;
        end
    end

    // Register file with registered reads.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_cmd.uop.dst] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_opa <= mem[i_cmd.uop.a];
            r_opb <= mem[i_cmd.uop.b];
        end
    end

    // Multiply and divide sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_act <= 1'b0;
            r_div_act <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_done <= wr_en;
            if (i_cmd.start && (i_cmd.uop.op == OP_MUL)) begin
                r_mul_act <= 1'b1;
                r_cnt     <= '0;
            end else if (i_cmd.start && (i_cmd.uop.op == OP_DIV) && (r_opb > 0)) begin
                r_div_act <= 1'b1;
                r_cnt     <= '0;
            end else if (r_mul_act) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(5)) begin
                    r_mul_act <= 1'b0;
                end
            end else if (r_div_act) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ND)) begin
                    r_div_act <= 1'b0;
                end
            end
        end
    end

    // Arithmetic unit payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && (i_cmd.uop.op == OP_MUL)) begin
            r_ma  <= mag(r_opa);
            r_mb  <= mag(r_opb);
            r_neg <= r_opa[W-1] ^ r_opb[W-1];
            r_acc <= '0;
        end else if (i_cmd.start && (i_cmd.uop.op == OP_DIV)) begin
            r_neg <= r_opa[W-1];
            r_den <= r_opb;
            r_dvd <= (ND'(mag(r_opa)) << F) + ND'(r_opb[W-1:1]);
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_mul_act) begin
            if (r_cnt < CNT_W'(4)) begin
                r_acc <= r_acc + ((2*W)'(pp) << (HW * (32'(r_cnt[0]) + 32'(r_cnt[1]))));
            end
            if (r_cnt == CNT_W'(4)) begin
                r_rnd <= RW'((r_acc + ((2*W)'(1) << (F - 1))) >> F);
            end
        end else if (r_div_act && (r_cnt < CNT_W'(ND))) begin
            r_rem <= qbit ? W'(remsh - {1'b0, r_den}) : remsh[W-1:0];
            r_quo <= {r_quo[ND-2:0], qbit};
            r_dvd <= {r_dvd[ND-2:0], 1'b0};
        end
    end

    // Measurement capture, saturation flag and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
        end else if (i_cmd.load) begin
            r_clip <= 1'b0;
        end else if (clip_set) begin
            r_clip <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z <= i_measurement;
        end
        if (wr_en) begin
            case (i_cmd.uop.dst)
                R_EP:    r_pos   <= wr_data;
                R_EV:    r_vel   <= wr_data;
                R_E:     r_innov <= wr_data;
                R_K0:    r_gpos  <= wr_data[32:0];
                R_K1:    r_gvel  <= wr_data[33:0];
                default: r_innov <= r_innov;
            endcase
        end
    end

    assign o_pos      = r_pos;
    assign o_vel      = r_vel;
    assign o_innov    = r_innov;
    assign o_gain_pos = r_gpos;
    assign o_gain_vel = r_gvel;
    assign o_sat      = r_clip;

endmodule

/* design/kalman_filter_cv_2state_unit.sv */
// Constant-velocity position/velocity tracker, one position measurement in,
// one estimate out, signed Q16.32 in 48-bit words.
// Input channel i_meas carries the measurement and a restart bit; a request
// is taken only while the unit is idle. Restart reloads position zero, the
// start velocity and a diagonal covariance before the step.
// Output channel o_est presents the updated position, velocity, innovation,
// the gains applied and a flag for any clipped value. The result is held
// until the receiver takes it; a stalled receiver holds off the next request.
// One request is taken per run of the step program over a shared register
// file; the next request is not taken until this result has been taken.
// A full covariance step runs the two 81-step restoring divisions and the 24
// multiplies done as four 24x24 partial products each. A divisor that is
// not positive skips both divisions.
// Configuration is to be written through i_cfg_we/i_cfg_idx/i_cfg_wdata only
// while idle; the block itself does not enforce this.
// Reset restores register defaults and the initial estimate, which the first
// request loads from the reset values unless it carries a restart.
module kalman_filter_cv_2state_unit import kfcv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kfcv_in_if.sink     i_meas,
    kfcv_out_if.source  o_est,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    kfcv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_meas.valid),
        .i_restart   (i_meas.restart),
        .o_in_ready  (i_meas.ready),
        .o_out_valid (o_est.valid),
        .i_out_ready (o_est.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kfcv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_measurement (i_meas.measurement),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (t_cfg_idx'(i_cfg_idx)),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_pos         (o_est.pos_estimate),
        .o_vel         (o_est.vel_estimate),
        .o_innov       (o_est.innovation),
        .o_gain_pos    (o_est.gain_pos_used),
        .o_gain_vel    (o_est.gain_vel_used),
        .o_sat         (o_est.saturated)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import kfcv_pkg::*;

    typedef struct {
        logic [47:0] meas;
        logic        restart;
    } t_meas_req;

    typedef struct packed {
        logic [47:0] pos;
        logic [47:0] vel;
        logic [47:0] innov;
        logic [32:0] gain_pos;
        logic [33:0] gain_vel;
        logic        sat;
    } t_estimate;

    localparam longint WORD_MAX = (longint'(1) <<< 47) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam longint UNITY    = longint'(1) <<< 32;
    localparam int     ITEMS_PER_PHASE = 154;
    localparam int     RANDOM_PHASES   = 8;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [47:0] i_cfg_wdata;

    kfcv_in_if  meas_ch ();
    kfcv_out_if est_ch ();

    kalman_filter_cv_2state_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_meas      (meas_ch.sink),
        .o_est       (est_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Tracker copy: configuration and state.
    longint trk_dt, trk_q, trk_r, trk_gp, trk_gv, trk_svel, trk_svar;
    logic   trk_mode;
    longint trk_pos, trk_vel, trk_cp, trk_cc, trk_cv;
    logic   trk_clip;

    t_meas_req pending_reqs[$];
    t_estimate expected_ests[$];
    int  mismatch_cnt;
    int  est_seen;
    int  restart_cnt;
    int  mode1_cnt;
    bit  sender_hold;
    bit  long_hold_req;

    // Saturating word helpers.
    function automatic longint word_sat(longint x);
        if (x > WORD_MAX) begin
            trk_clip = 1'b1;
            return WORD_MAX;
        end
        if (x < WORD_MIN) begin
            trk_clip = 1'b1;
            return WORD_MIN;
        end
        return x;
    endfunction

    function automatic longint word_from_mag(logic [127:0] m, logic neg);
        logic [127:0] lim;
        lim = 128'(WORD_MAX) + 128'(neg);
        if (m > lim) begin
            trk_clip = 1'b1;
            m = lim;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic [127:0] word_mag(longint a);
        return 128'(a < 0 ? -a : a);
    endfunction

    // Fixed-point product, rounded half away from zero.
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        p = word_mag(a) * word_mag(b);
        p = (p + (128'(1) << 31)) >> 32;
        return word_from_mag(p, (a < 0) != (b < 0));
    endfunction

    // Fixed-point quotient for a positive divisor, rounded to nearest.
    function automatic longint fx_div(longint num, longint den);
        logic [127:0] n;
        n = (word_mag(num) << 32) + (128'(den) >> 1);
        return word_from_mag(n / 128'(den), num < 0);
    endfunction

    function automatic void trk_restart();
        trk_pos = 0;
        trk_vel = trk_svel;
        trk_cp  = trk_svar;
        trk_cv  = trk_svar;
        trk_cc  = 0;
    endfunction

    function automatic void trk_config(t_cfg_idx idx, logic [47:0] v);
        case (idx)
            CFG_TIME_STEP:   trk_dt = longint'(v[36:0]);
            CFG_ACCEL_NOISE: trk_q = longint'(v[46:0]);
            CFG_MEAS_NOISE:  trk_r = longint'(v[46:0]);
            CFG_FILTER_MODE: trk_mode = v[0];
            CFG_GAIN_POS:    trk_gp = longint'(v[32:0]);
            CFG_GAIN_VEL:    trk_gv = longint'(v[32:0]);
            CFG_START_VEL:   trk_svel = longint'(signed'(v));
            default:         trk_svar = longint'(v[46:0]);
        endcase
    endfunction

    // One tracker step: predict, gain, update.
    function automatic t_estimate track_step(t_meas_req req);
        longint z, xp, e, k0, k1;
        longint dt2, dt3, dt4, t, q00, q01, q11, m00, m01, p00, p01, p11, s, a, b;
        longint t00, t01, t10, t11, kr0, kr1;
        t_estimate res;
        trk_clip = 1'b0;
        if (req.restart) trk_restart();
        z  = longint'(signed'(req.meas));
        xp = word_sat(trk_pos + fx_mul(trk_dt, trk_vel));
        e  = word_sat(z - xp);
        if (trk_mode) begin
            k0 = trk_gp;
            k1 = trk_gv;
        end else begin
            dt2 = fx_mul(trk_dt, trk_dt);
            dt3 = fx_mul(dt2, trk_dt);
            dt4 = fx_mul(dt2, dt2);
            t   = fx_mul(trk_q, dt4);
            q00 = (t >>> 2) + ((t >>> 1) & 1);
            t   = fx_mul(trk_q, dt3);
            q01 = (t >>> 1) + (t & 1);
            q11 = fx_mul(trk_q, trk_dt);
            m00 = word_sat(trk_cp + fx_mul(trk_dt, trk_cc));
            m01 = word_sat(trk_cc + fx_mul(trk_dt, trk_cv));
            p00 = word_sat(word_sat(m00 + fx_mul(trk_dt, m01)) + q00);
            p01 = word_sat(m01 + q01);
            p11 = word_sat(trk_cv + q11);
            s   = word_sat(p00 + trk_r);
            if (s > 0) begin
                k0 = fx_div(p00, s);
                k1 = fx_div(p01, s);
            end else begin
                k0 = 0;
                k1 = 0;
            end
            if (k0 < 0) begin
                k0 = 0;
                trk_clip = 1'b1;
            end
            if (k0 > UNITY) begin
                k0 = UNITY;
                trk_clip = 1'b1;
            end
            if (k1 < -UNITY) begin
                k1 = -UNITY;
                trk_clip = 1'b1;
            end
            if (k1 > UNITY) begin
                k1 = UNITY;
                trk_clip = 1'b1;
            end
            a   = word_sat(UNITY - k0);
            b   = -k1;
            t00 = fx_mul(a, p00);
            t01 = fx_mul(a, p01);
            t10 = word_sat(fx_mul(b, p00) + p01);
            t11 = word_sat(fx_mul(b, p01) + p11);
            kr0 = fx_mul(k0, trk_r);
            kr1 = fx_mul(k1, trk_r);
            trk_cp = word_sat(fx_mul(t00, a) + fx_mul(kr0, k0));
            trk_cc = word_sat(word_sat(fx_mul(t00, b) + t01) + fx_mul(kr0, k1));
            trk_cv = word_sat(word_sat(fx_mul(t10, b) + t11) + fx_mul(kr1, k1));
        end
        trk_pos = word_sat(xp + fx_mul(k0, e));
        trk_vel = word_sat(trk_vel + fx_mul(k1, e));
        res.pos      = trk_pos[47:0];
        res.vel      = trk_vel[47:0];
        res.innov    = e[47:0];
        res.gain_pos = k0[32:0];
        res.gain_vel = k1[33:0];
        res.sat      = trk_clip;
        return res;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Request driver: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            meas_ch.valid <= 1'b0;
            burst_left    <= 1;
            gap_left      <= 0;
        end else begin
            if (meas_ch.valid && meas_ch.ready) begin
                expected_ests.push_back(track_step(pending_reqs[0]));
                if (pending_reqs[0].restart) restart_cnt++;
                if (trk_mode) mode1_cnt++;
                pending_reqs.pop_front();
            end
            if (meas_ch.valid && !meas_ch.ready) begin
                // Hold the offered request.
            end else if (meas_ch.valid && burst_left <= 1) begin
                meas_ch.valid <= 1'b0;
                burst_left    <= $urandom_range(1, 6);
                gap_left      <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0 && !sender_hold) begin
                if (meas_ch.valid) burst_left <= burst_left - 1;
                meas_ch.valid       <= 1'b1;
                meas_ch.measurement <= pending_reqs[0].meas;
                meas_ch.restart     <= pending_reqs[0].restart;
            end else begin
                meas_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    int stall_left;
    int hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            est_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
        end else if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold_left     <= 3000;
            est_ch.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            est_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            est_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 12);
            est_ch.ready <= 1'b0;
        end else begin
            est_ch.ready <= 1'b1;
        end
    end

    // Result monitor: compare each estimate with the oldest prediction.
    always @(posedge i_clk) begin
        t_estimate exp_est;
        t_estimate got;
        if (i_rst_n && est_ch.valid && est_ch.ready) begin
            got.pos      = est_ch.pos_estimate;
            got.vel      = est_ch.vel_estimate;
            got.innov    = est_ch.innovation;
            got.gain_pos = est_ch.gain_pos_used;
            got.gain_vel = est_ch.gain_vel_used;
            got.sat      = est_ch.saturated;
            est_seen++;
            if (expected_ests.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("Estimate %0d arrived with none pending", est_seen);
            end else begin
                exp_est = expected_ests.pop_front();
                if (got != exp_est) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("Estimate %0d differs:", est_seen);
                        $display("  pos exp %h got %h, vel exp %h got %h",
                                 exp_est.pos, got.pos, exp_est.vel, got.vel);
                        $display("  innov exp %h got %h, gains exp %h/%h got %h/%h",
                                 exp_est.innov, got.innov, exp_est.gain_pos,
                                 exp_est.gain_vel, got.gain_pos, got.gain_vel);
                        $display("  saturated exp %b got %b", exp_est.sat, got.sat);
                    end
                end
            end
        end
    end

    // Register writes; the caller drops the write enable afterwards.
    task automatic cfg_write(t_cfg_idx idx, logic [47:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        trk_config(idx, v);
    endtask

    task automatic cfg_all(logic [47:0] dt, logic [47:0] q, logic [47:0] r,
                           logic [47:0] mode, logic [47:0] gp, logic [47:0] gv,
                           logic [47:0] svel, logic [47:0] svar);
        cfg_write(CFG_TIME_STEP, dt);
        cfg_write(CFG_ACCEL_NOISE, q);
        cfg_write(CFG_MEAS_NOISE, r);
        cfg_write(CFG_FILTER_MODE, mode);
        cfg_write(CFG_GAIN_POS, gp);
        cfg_write(CFG_GAIN_VEL, gv);
        cfg_write(CFG_START_VEL, svel);
        cfg_write(CFG_START_VAR, svar);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    endfunction

    // Unused upper write bits carry noise.
    function automatic logic [47:0] with_noise(logic [47:0] v, int width);
        logic [47:0] m;
        m = (48'd1 << width) - 48'd1;
        return (v & m) | (rand48() & ~m);
    endfunction

    task automatic push_req(logic [47:0] meas, logic restart);
        t_meas_req req;
        req.meas    = meas;
        req.restart = restart;
        pending_reqs.push_back(req);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || meas_ch.valid || expected_ests.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Random configuration that mostly keeps the filter well conditioned.
    task automatic cfg_random();
        logic [47:0] dt, q, r, gp, gv, svar;
        case ($urandom_range(0, 9))
            0:       dt = 48'd1;
            1:       dt = 48'h10_0000_0000;
            2:       dt = rand48();
            default: dt = 48'(longint'($urandom_range(1, 1 << 30)) <<< 2);
        endcase
        case ($urandom_range(0, 9))
            0:       q = 48'd0;
            1:       q = 48'h7FFF_FFFF_FFFF;
            2:       q = rand48();
            default: q = 48'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       r = 48'd1;
            1:       r = 48'h7FFF_FFFF_FFFF;
            2:       r = rand48();
            default: r = 48'(longint'($urandom) <<< $urandom_range(0, 6));
        endcase
        gp = ($urandom_range(0, 4) == 0) ? rand48() : 48'($urandom_range(0, 32'hFFFF_FFFF));
        gv = ($urandom_range(0, 4) == 0) ? rand48() : 48'($urandom_range(0, 32'hFFFF_FFFF));
        svar = ($urandom_range(0, 5) == 0) ? rand48() :
               48'(longint'($urandom) <<< $urandom_range(0, 10));
        cfg_all(with_noise(dt, 37), with_noise(q, 47), with_noise(r, 47),
                with_noise(48'($urandom_range(0, 1)), 1), with_noise(gp, 33),
                with_noise(gv, 33), rand48(), with_noise(svar, 47));
    endtask

    // Random measurement: mostly near a track, sometimes anywhere.
    function automatic logic [47:0] rand_meas(int step);
        case ($urandom_range(0, 9))
            0:       return rand48();
            1:       return ($urandom_range(0, 1) == 0) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            default: return 48'(longint'(step) * (longint'(1) <<< 31) +
                                longint'($urandom_range(0, 1 << 20)) * 8192 -
                                (longint'(1) <<< 32));
        endcase
    endfunction

    // Stimulus sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_TIME_STEP;
        i_cfg_wdata   = '0;
        meas_ch.valid = 1'b0;
        meas_ch.measurement = '0;
        meas_ch.restart     = 1'b0;
        est_ch.ready  = 1'b0;
        sender_hold   = 1'b0;
        long_hold_req = 1'b0;
        mismatch_cnt  = 0;
        est_seen      = 0;
        restart_cnt   = 0;
        mode1_cnt     = 0;
        trk_dt   = longint'(RST_TIME_STEP);
        trk_q    = longint'(RST_ACCEL_NOISE);
        trk_r    = longint'(RST_MEAS_NOISE);
        trk_mode = 1'b0;
        trk_gp   = 0;
        trk_gv   = 0;
        trk_svel = longint'(signed'(RST_START_VEL));
        trk_svar = longint'(RST_START_VAR);
        trk_restart();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, field extremes and restart.
        push_req(48'd0, 1'b0);
        push_req(48'h7FFF_FFFF_FFFF, 1'b0);
        push_req(48'h8000_0000_0000, 1'b0);
        push_req(48'h0001_0000_0000, 1'b1);
        push_req(48'h0002_0000_0000, 1'b0);
        push_req(48'hFFFF_FFFF_FFFF, 1'b0);
        wait_idle();

        // Large step, noise and variance: saturation everywhere.
        cfg_all(48'h10_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'd0,
                48'd0, 48'd0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        push_req(48'h7FFF_FFFF_FFFF, 1'b1);
        push_req(48'h8000_0000_0000, 1'b0);
        push_req(48'h1234_5678_9ABC, 1'b0);
        wait_idle();

        // Tiny step and measurement variance, zero start variance.
        cfg_all(48'd1, 48'd0, 48'd1, 48'd0, 48'd0, 48'd0, 48'h7FFF_FFFF_FFFF, 48'd0);
        push_req(48'd5, 1'b1);
        push_req(48'h8000_0000_0000, 1'b0);
        push_req(48'h7FFF_FFFF_FFFF, 1'b0);
        wait_idle();

        // Fixed gains: zero, unity, and beyond unity.
        cfg_all(48'h1_0000_0000, 48'd0, 48'd1, 48'd1, 48'd0, 48'd0, 48'd0, 48'd0);
        push_req(48'h0003_0000_0000, 1'b1);
        push_req(48'h8000_0000_0000, 1'b0);
        wait_idle();
        cfg_all(48'h1_0000_0000, 48'd0, 48'd1, 48'd1, 48'h1_0000_0000,
                48'h1_0000_0000, 48'd0, 48'd0);
        push_req(48'h0003_0000_0000, 1'b1);
        push_req(48'h7FFF_FFFF_FFFF, 1'b0);
        wait_idle();
        cfg_all(48'h1_0000_0000, 48'd0, 48'd1, 48'd1, 48'h1_FFFF_FFFF,
                48'h1_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'd0);
        push_req(48'h8000_0000_0000, 1'b1);
        push_req(48'h0000_0000_0001, 1'b0);
        push_req(48'h7FFF_FFFF_FFFF, 1'b0);
        wait_idle();

        // Random phases; the second one holds the receiver off for a while.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            cfg_random();
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_req(rand_meas(i), (i == 0) || ($urandom_range(0, 19) == 0));
            if (ph == 1) begin
                repeat (200) @(posedge i_clk);
                long_hold_req <= 1'b1;
            end
            wait_idle();
        end

        repeat (600) @(posedge i_clk);
        $display("Checked %0d estimates over %0d random setups plus directed extremes,",
                 est_seen, RANDOM_PHASES);
        $display("%0d restarts and %0d fixed-gain steps.", restart_cnt, mode1_cnt);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatching estimates", mismatch_cnt);
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #40_000_000;
        $display("Timed out with %0d requests and %0d estimates outstanding",
                 pending_reqs.size(), expected_ests.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

/* kalman_filter_cv_2state_unit.f */
+incdir+design
design/kfcv_pkg.sv
design/kfcv_in_if.sv
design/kfcv_out_if.sv
design/kfcv_ctrl.sv
design/kfcv_dp.sv
design/kalman_filter_cv_2state_unit.sv
tb/tb_top.sv
